// ----- rtl/core/srmsb_pkg.sv -----
`default_nettype none

package srmsb_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TAKES_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TAKES_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TAKES_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TAKES_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE           = 3'd4;

    // Balance scale: Q1.15, one at 32768, neutral at half.
    localparam int BAL_W     = 16;
    localparam int FRAC_BITS = 14;
    localparam logic [BAL_W-1:0] BAL_HALF = 16'd16384;
    localparam logic [BAL_W-1:0] BAL_ONE  = 16'd32768;

    // Mixing coefficients are unsigned and never exceed BAL_ONE.
    localparam int COEF_W = 16;

    typedef struct packed {
        logic             left_takes_left;
        logic             left_takes_right;
        logic             right_takes_left;
        logic             right_takes_right;
        logic [BAL_W-1:0] balance;
    } t_cfg;

    // Weight on the routed signal, weight on the second term, and whether
    // the second term is side (upper half of the balance range) or mid.
    typedef struct packed {
        logic [COEF_W-1:0] c_sig;
        logic [COEF_W-1:0] c_alt;
        logic              use_side;
    } t_coef;

endpackage

`default_nettype wire

// ----- rtl/core/srmsb_cfg_regs.sv -----
`default_nettype none

module srmsb_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [srmsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srmsb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output srmsb_pkg::t_cfg                       o_cfg,
    output srmsb_pkg::t_coef                      o_coef
);
    import srmsb_pkg::*;

    t_cfg             r_cfg;
    logic [BAL_W-1:0] w_bal;

    // Register file; writes to unknown indexes fall through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_takes_left   <= 1'b1;
            r_cfg.left_takes_right  <= 1'b0;
            r_cfg.right_takes_left  <= 1'b0;
            r_cfg.right_takes_right <= 1'b1;
            r_cfg.balance           <= BAL_HALF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LEFT_TAKES_LEFT:   r_cfg.left_takes_left   <= i_cfg_data[0];
                REG_LEFT_TAKES_RIGHT:  r_cfg.left_takes_right  <= i_cfg_data[0];
                REG_RIGHT_TAKES_LEFT:  r_cfg.right_takes_left  <= i_cfg_data[0];
                REG_RIGHT_TAKES_RIGHT: r_cfg.right_takes_right <= i_cfg_data[0];
                REG_BALANCE:           r_cfg.balance           <= i_cfg_data[BAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Balance above one acts as one.
    assign w_bal = (r_cfg.balance > BAL_ONE) ? BAL_ONE : r_cfg.balance;

    // Lower half blends mid into the routed signal; upper half blends the
    // routed signal into doubled side. Neutral gives the routed signal alone.
    always_comb begin
        if (w_bal <= BAL_HALF) begin
            o_coef.c_sig    = w_bal;
            o_coef.c_alt    = BAL_HALF - w_bal;
            o_coef.use_side = 1'b0;
        end else begin
            o_coef.c_sig    = BAL_ONE - w_bal;
            o_coef.c_alt    = (w_bal - BAL_HALF) << 1;
            o_coef.use_side = 1'b1;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/srmsb_route.sv -----
`default_nettype none

module srmsb_route #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right,
    input  wire srmsb_pkg::t_cfg               i_cfg,
    input  wire srmsb_pkg::t_coef              i_coef,
    output logic signed [SAMPLE_BITS-1:0]      o_sig_l,
    output logic signed [SAMPLE_BITS-1:0]      o_sig_r,
    output logic signed [SAMPLE_BITS:0]        o_alt_l,
    output logic signed [SAMPLE_BITS:0]        o_alt_r,
    output srmsb_pkg::t_coef                   o_coef
);
    import srmsb_pkg::*;

    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS-1:0] w_mid;
    logic signed [SAMPLE_BITS-1:0] n_sig_l;
    logic signed [SAMPLE_BITS-1:0] n_sig_r;
    logic signed [SAMPLE_BITS:0]   w_side_l;
    logic signed [SAMPLE_BITS:0]   w_side_r;
    logic signed [SAMPLE_BITS:0]   w_mid_x;

    function automatic logic signed [SAMPLE_BITS-1:0] pick(
        input logic                          take_l,
        input logic                          take_r,
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input logic signed [SAMPLE_BITS-1:0] mid
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (take_l && take_r) begin
            res = mid;
        end else if (take_l) begin
            res = l;
        end else if (take_r) begin
            res = r;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    // Mid is the floor average; the sum carries one extra bit.
    assign w_sum = {i_left[SAMPLE_BITS-1], i_left} + {i_right[SAMPLE_BITS-1], i_right};
    assign w_mid = w_sum[SAMPLE_BITS:1];

    assign n_sig_l = pick(i_cfg.left_takes_left, i_cfg.left_takes_right,
                          i_left, i_right, w_mid);
    assign n_sig_r = pick(i_cfg.right_takes_left, i_cfg.right_takes_right,
                          i_left, i_right, w_mid);

    // Side is exact, so it needs one bit more than a sample.
    assign w_mid_x  = {w_mid[SAMPLE_BITS-1], w_mid};
    assign w_side_l = {n_sig_l[SAMPLE_BITS-1], n_sig_l} - w_mid_x;
    assign w_side_r = {n_sig_r[SAMPLE_BITS-1], n_sig_r} - w_mid_x;

    // First pipeline register: routed signals, second terms and weights.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_sig_l <= n_sig_l;
            o_sig_r <= n_sig_r;
            o_alt_l <= i_coef.use_side ? w_side_l : w_mid_x;
            o_alt_r <= i_coef.use_side ? w_side_r : w_mid_x;
            o_coef  <= i_coef;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/srmsb_mix_lane.sv -----
`default_nettype none

module srmsb_mix_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_load_mul,
    input  wire logic                          i_load_out,
    input  wire srmsb_pkg::t_coef              i_coef,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sig,
    input  wire logic signed [SAMPLE_BITS:0]   i_alt,
    output logic signed [SAMPLE_BITS-1:0]      o_result
);
    import srmsb_pkg::*;

    localparam int X_W   = SAMPLE_BITS + 1;
    localparam int P_W   = X_W + COEF_W + 1;
    localparam int ACC_W = P_W + 1;
    localparam int SH_W  = ACC_W - FRAC_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [P_W-1:0]         r_p_sig;
    logic signed [P_W-1:0]         r_p_alt;
    logic signed [ACC_W-1:0]       w_acc;
    logic signed [SH_W-1:0]        w_sh;
    logic signed [SAMPLE_BITS-1:0] n_result;
    logic signed [COEF_W:0]        w_c_sig;
    logic signed [COEF_W:0]        w_c_alt;
    logic signed [X_W-1:0]         w_sig_x;

    assign w_c_sig = $signed({1'b0, i_coef.c_sig});
    assign w_c_alt = $signed({1'b0, i_coef.c_alt});
    assign w_sig_x = {i_sig[SAMPLE_BITS-1], i_sig};

    // Second pipeline register: the two weighted terms.
    always_ff @(posedge i_clk) begin
        if (i_load_mul) begin
            r_p_sig <= w_c_sig * w_sig_x;
            r_p_alt <= w_c_alt * i_alt;
        end
    end

    // Sum, floor shift by the fraction width, then clamp to the sample range.
    assign w_acc = {r_p_sig[P_W-1], r_p_sig} + {r_p_alt[P_W-1], r_p_alt};
    assign w_sh  = w_acc[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (&w_sh[SH_W-1:SAMPLE_BITS-1] || ~|w_sh[SH_W-1:SAMPLE_BITS-1]) begin
            n_result = w_sh[SAMPLE_BITS-1:0];
        end else if (w_sh[SH_W-1]) begin
            n_result = SAT_MIN;
        end else begin
            n_result = SAT_MAX;
        end
    end

    // Third pipeline register doubles as the output register.
    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            o_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stereo_route_mid_side_balance.sv -----
`default_nettype none
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_stall    i_left_sample, i_right_sample
// out       source     o_out_valid / i_out_stall  o_left_result, o_right_result
// cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// Three register stages (route, multiply, sum and clamp); one word per cycle
// is sustained while the output is not stalled.
// The two multipliers per channel in the middle stage set the clock period.
// Synchronous active-low reset clears the valid bits and loads the register
// reset values. An output stall holds a full stage only if all later stages
// are full; empty stages fill, so the input stalls only when all three are full.

module stereo_route_mid_side_balance #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_right_sample,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_left_result,
    output logic signed [SAMPLE_BITS-1:0]         o_right_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [srmsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srmsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srmsb_pkg::*;

    t_cfg  w_cfg;
    t_coef w_coef;
    t_coef w_coef_s1;

    logic signed [SAMPLE_BITS-1:0] w_sig_l;
    logic signed [SAMPLE_BITS-1:0] w_sig_r;
    logic signed [SAMPLE_BITS:0]   w_alt_l;
    logic signed [SAMPLE_BITS:0]   w_alt_r;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_en1;
    logic w_en2;
    logic w_en3;

    // A stage loads when it is empty or its contents move on.
    assign w_en3 = !r_v3 || !i_out_stall;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign o_in_stall  = !w_en1;
    assign o_out_valid = r_v3;

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    srmsb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_coef      (w_coef)
    );

    srmsb_route #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_route (
        .i_clk   (i_clk),
        .i_load  (w_en1),
        .i_left  (i_left_sample),
        .i_right (i_right_sample),
        .i_cfg   (w_cfg),
        .i_coef  (w_coef),
        .o_sig_l (w_sig_l),
        .o_sig_r (w_sig_r),
        .o_alt_l (w_alt_l),
        .o_alt_r (w_alt_r),
        .o_coef  (w_coef_s1)
    );

    srmsb_mix_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix_l (
        .i_clk      (i_clk),
        .i_load_mul (w_en2),
        .i_load_out (w_en3),
        .i_coef     (w_coef_s1),
        .i_sig      (w_sig_l),
        .i_alt      (w_alt_l),
        .o_result   (o_left_result)
    );

    srmsb_mix_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix_r (
        .i_clk      (i_clk),
        .i_load_mul (w_en2),
        .i_load_out (w_en3),
        .i_coef     (w_coef_s1),
        .i_sig      (w_sig_r),
        .i_alt      (w_alt_r),
        .o_result   (o_right_result)
    );

    // The input stalls only when the whole pipeline is full and held.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && i_out_stall))
        else $error("input stalled while the pipeline has room");

    // An accepted word occupies the first stage on the next cycle.
    a_accept_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted word lost at the first stage");

    // While the output is held nothing can leave, so occupancy cannot drop.
    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_out_stall) |=>
        ($countones({r_v1, r_v2, r_v3}) >= $past($countones({r_v1, r_v2, r_v3}))))
        else $error("word dropped while the output was stalled");

endmodule

`default_nettype wire
